### hw/rtl/ffq_pkg.sv
// Package for the float fixed-point quantizer.
// Holds register indexes, widths and the limit-pattern helper function.
// No dependencies.
package ffq_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;

  typedef enum logic [CfgIdxW-1:0] {
    REG_INT_BITS      = 1'b0,
    REG_FRACTION_BITS = 1'b1
  } cfg_reg_t;

  // Effective settings after saturation into the legal ranges.
  typedef struct packed {
    logic [5:0]  n;
    logic [31:0] rmax;
    logic [31:0] rmin_mag;
  } limits_t;

  // Positive upper limit: float of 2^(m-1) - 2^-n, m in 1..32, n in 0..32.
  function automatic logic [31:0] upper_limit(input logic [5:0] m, input logic [5:0] n);
    logic [6:0] c;
    logic [6:0] cm1;
    logic [7:0] ex;
    logic [22:0] frac;
    c = 7'(m) - 7'd1 + 7'(n);
    cm1 = c - 7'd1;
    ex = 8'(m) + 8'd125;
    // The leading one is implicit, so the mantissa holds the other c-1 ones.
    frac = ~(23'h7FFFFF >> cm1[4:0]);
    if (c > 7'd24) begin
      upper_limit = {1'b0, 8'(8'(m) + 8'd126), 23'd0};
    end else if (c == 7'd0) begin
      upper_limit = 32'd0;
    end else begin
      upper_limit = {1'b0, ex, frac};
    end
  endfunction

endpackage

### hw/rtl/ffq_if.sv
// Valid/ready channel interfaces for the quantizer.
// Depends on ffq_pkg for the configuration widths.
interface ffq_data_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface ffq_cfg_if;
  import ffq_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/ffq_cfg.sv
// Configuration registers and precomputed limits for the quantizer.
// Depends on ffq_pkg and ffq_cfg_if.
module ffq_cfg
  import ffq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  ffq_cfg_if.sink   cfg,
  output limits_t   lim
);
  logic [5:0] int_bits;
  logic [5:0] fraction_bits;
  logic [5:0] m_eff;
  logic [5:0] n_eff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      int_bits      <= 6'd8;
      fraction_bits <= 6'd8;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_INT_BITS:      int_bits      <= cfg.data;
        REG_FRACTION_BITS: fraction_bits <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    m_eff = int_bits;
    if (m_eff == 6'd0) m_eff = 6'd1;
    if (m_eff > 6'd32) m_eff = 6'd32;
    n_eff = (fraction_bits > 6'd32) ? 6'd32 : fraction_bits;
  end

  // Limits are registered; the user must change config only while idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    lim.n        <= n_eff;
    lim.rmax     <= upper_limit(m_eff, n_eff);
    lim.rmin_mag <= {1'b0, 8'(8'(m_eff) + 8'd126), 23'd0};
  end
endmodule

### hw/rtl/ffq_core.sv
// Combinational quantization of one float32 sample.
// Depends on ffq_pkg.
module ffq_core
  import ffq_pkg::*;
(
  input  logic [31:0] x,
  input  limits_t     lim,
  output logic [31:0] y
);
  logic [30:0] mag;
  logic        sgn;
  logic [9:0]  k;

  assign mag = x[30:0];
  assign sgn = x[31];
  // k = 150 - exp - n, signed 10 bits
  assign k = 10'd150 - 10'(mag[30:23]) - 10'(lim.n);

  always_comb begin
    if (mag > 31'h7F800000) begin
      y = x;
    end else if (!sgn && {1'b0, mag} > lim.rmax) begin
      y = lim.rmax;
    end else if (sgn && {1'b0, mag} > lim.rmin_mag) begin
      y = {1'b1, lim.rmin_mag[30:0]};
    end else if (mag[30:23] == 8'd0) begin
      y = {sgn, 31'd0};
    end else if (k[9] || k == 10'd0) begin
      y = x;
    end else if (k >= 10'd24) begin
      y = {sgn, 31'd0};
    end else begin
      y = x & ~((32'd1 << k[4:0]) - 32'd1);
    end
  end
endmodule

### hw/rtl/float_fixed_point_quantizer_top.sv
// Top level of the float fixed-point quantizer.
// Depends on ffq_pkg, the channel interfaces, ffq_cfg and ffq_core.
//
// The block takes one IEEE single-precision sample per transfer and returns it
// clipped to a signed fixed-point range with a programmable number of integer
// bits (sign included) and truncated toward zero to fraction_bits fraction
// bits, still as a float32.
// NaN passes through unchanged and zero keeps its sign. One sample is taken
// every cycle unless the output stalls; each result appears in the cycle after
// its transfer, from one output register refilled in the same cycle it drains.
// Configuration writes are always accepted; register 0 sets the integer bits
// and register 1 is fraction_bits. Write them only while no samples are in
// flight, and allow one cycle after a write before the next sample.
module float_fixed_point_quantizer_top
  import ffq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ffq_cfg_if.sink    cfg,
  ffq_data_if.sink   din,
  ffq_data_if.source dout
);
  limits_t     lim;
  logic [31:0] q;
  logic        out_valid;
  logic [31:0] out_value;

  ffq_cfg u_cfg (.clk(clk), .rst(rst), .cfg(cfg), .lim(lim));
  ffq_core u_core (.x(din.value), .lim(lim), .y(q));

  // The output register accepts a new sample whenever it is empty or drained.
  assign din.ready  = !out_valid || dout.ready;
  assign dout.valid = out_valid;
  assign dout.value = out_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (din.ready) begin
      out_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      out_value <= q;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !dout.ready |=> out_valid && $stable(out_value))
    else $error("result lost under stall");
  a_take: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> out_valid)
    else $error("accepted sample gave no result");
  a_nan: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready && din.value[30:0] > 31'h7F800000
    |=> out_value == $past(din.value))
    else $error("NaN not passed through");
endmodule

### tb/sv/tb_top.sv
// Testbench for the float fixed-point quantizer.
// Depends on ffq_pkg, the ffq_data_if and ffq_cfg_if interfaces and
// float_fixed_point_quantizer_top.
module tb_top;
  import ffq_pkg::*;

  // Directed stimulus row: an optional expected result is typed in where
  // it can be read off at a glance; otherwise the predictor decides.
  typedef struct {
    logic [31:0] sample;
    bit          typed;
    logic [31:0] want;
  } stim_row_t;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned RandomItems   = 1300;

  logic clk;
  logic rst;

  ffq_cfg_if  cfg ();
  ffq_data_if din ();
  ffq_data_if dout ();

  float_fixed_point_quantizer_top uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .din (din),
    .dout(dout)
  );

  // Testbench copy of the two registers, as written through the port.
  logic [5:0] range_reg;
  logic [5:0] fraction_reg;

  // Quantized values still to come out of the block, oldest first.
  logic [31:0] pending_values[$];

  int unsigned mismatch_count;
  int unsigned sent_count;
  int unsigned recv_count;
  int unsigned idle_cycles;
  bit          calm;          // when set, neither side idles
  bit          hold_sink;     // long stall of the receiver

  stim_row_t directed[$];

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Expected output for one sample under the current register copy.
  function automatic logic [31:0] quantize_sample(input logic [31:0] x);
    logic [5:0]  m;
    logic [5:0]  n;
    int          c;
    int          k;
    int          ebias;
    logic [31:0] mag;
    logic [31:0] sgn;
    logic [31:0] rmax;
    logic [31:0] rmin_mag;
    logic [22:0] ones;
    m = (range_reg == 6'd0) ? 6'd1 : (range_reg > 6'd32) ? 6'd32 : range_reg;
    n = (fraction_reg > 6'd32) ? 6'd32 : fraction_reg;
    mag = x & 32'h7FFF_FFFF;
    sgn = x & 32'h8000_0000;
    c = int'(m) - 1 + int'(n);
    if (c > 24) begin
      rmax = (32'(m) - 1 + 127) << 23;
    end else if (c == 0) begin
      rmax = 32'd0;
    end else begin
      ones = 23'((32'd1 << (c - 1)) - 1) << (23 - (c - 1));
      rmax = ((32'(m) + 125) << 23) | 32'(ones);
    end
    rmin_mag = (32'(m) - 1 + 127) << 23;
    if (mag > 32'h7F80_0000) begin
      return x;
    end
    if (sgn == 0 && mag > rmax) begin
      return rmax;
    end
    if (sgn != 0 && mag > rmin_mag) begin
      return 32'h8000_0000 | rmin_mag;
    end
    ebias = int'(mag >> 23);
    if (ebias == 0) begin
      return sgn;
    end
    k = 23 - (ebias - 127) - int'(n);
    if (k <= 0) begin
      return x;
    end
    if (k >= 24) begin
      return sgn;
    end
    return x & ~((32'd1 << k) - 1);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %08h want %08h (m=%0d n=%0d)", what, got, want,
             range_reg, fraction_reg);
  endtask

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 32);
  endfunction

  // Receiver: ready toggles at random, and is held low during the long stall.
  always @(posedge clk) begin
    if (rst) begin
      dout.ready <= 1'b0;
    end else begin
      dout.ready <= !hold_sink && !idle_now();
    end
  end

  // Checker: compare each output transfer with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && dout.valid && dout.ready) begin
      recv_count++;
      if (pending_values.size() == 0) begin
        report_mismatch("unexpected value_out", dout.value, 32'hx);
      end else begin
        logic [31:0] want;
        want = pending_values.pop_front();
        if (dout.value !== want) begin
          report_mismatch("value_out", dout.value, want);
        end
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel, outside the long stall.
  always @(posedge clk) begin
    if ((din.valid && din.ready) || (dout.valid && dout.ready) ||
        (cfg.valid && cfg.ready) || hold_sink) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d values outstanding",
                 pending_values.size());
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one sample and waits for its transfer; the expectation is queued
  // at the accepting edge, so a typed expectation is checked there too.
  task automatic send_sample(input logic [31:0] x, input bit typed,
                             input logic [31:0] want);
    logic [31:0] q;
    while (idle_now()) begin
      din.valid <= 1'b0;
      @(posedge clk);
    end
    din.valid <= 1'b1;
    din.value <= x;
    do begin
      @(posedge clk);
    end while (!din.ready);
    q = quantize_sample(x);
    if (typed && q !== want) begin
      report_mismatch("typed row", q, want);
    end
    pending_values.push_back(typed ? want : q);
    sent_count++;
  endtask

  // Waits for the block to drain, then writes one register.
  task automatic write_register(input cfg_reg_t idx, input logic [5:0] val);
    din.valid <= 1'b0;
    @(posedge clk);
    while (pending_values.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == REG_INT_BITS) begin
      range_reg = val;
    end else begin
      fraction_reg = val;
    end
    @(posedge clk);
  endtask

  // Random float: mostly exponents near the grid, plus specials and noise.
  function automatic logic [31:0] random_sample();
    logic [31:0] x;
    x = $urandom();
    case ($urandom_range(9))
      0: x[30:23] = 8'hFF;
      1: x[30:23] = 8'h00;
      2, 3: x[30:23] = 8'($urandom_range(90, 170));
      4, 5, 6: x[30:23] = 8'(127 + int'(range_reg) - 3 + $urandom_range(4));
      default: x[30:23] = 8'($urandom_range(110, 140));
    endcase
    return x;
  endfunction

  task automatic add_row(input logic [31:0] x, input bit typed,
                         input logic [31:0] want);
    stim_row_t r;
    r.sample = x;
    r.typed  = typed;
    r.want   = want;
    directed.push_back(r);
  endtask

  initial begin
    logic [5:0] settings[12][2];
    rst = 1'b1;
    din.valid = 1'b0;
    din.value = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_INT_BITS;
    cfg.data  = '0;
    range_reg = 6'd8;
    fraction_reg = 6'd8;
    mismatch_count = 0;
    sent_count = 0;
    recv_count = 0;
    idle_cycles = 0;
    calm = 1'b0;
    hold_sink = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows under the reset setting, m = 8 and n = 8: upper limit
    // 127.99609375 (42FFFE00), lower bound -128 (C3000000).
    add_row(32'h0000_0000, 1, 32'h0000_0000);  // positive zero
    add_row(32'h8000_0000, 1, 32'h8000_0000);  // negative zero keeps sign
    add_row(32'h7F80_0000, 1, 32'h42FF_FE00);  // +inf to upper limit
    add_row(32'hFF80_0000, 1, 32'hC300_0000);  // -inf to lower bound
    add_row(32'h7FC0_0001, 1, 32'h7FC0_0001);  // quiet NaN unchanged
    add_row(32'hFF80_0001, 1, 32'hFF80_0001);  // negative signaling NaN
    add_row(32'h0000_0001, 1, 32'h0000_0000);  // subnormal to zero
    add_row(32'h807F_FFFF, 1, 32'h8000_0000);  // negative subnormal
    add_row(32'hBB00_0000, 1, 32'h8000_0000);  // tiny negative to -0
    add_row(32'h4300_0000, 1, 32'h42FF_FE00);  // +128 saturates
    add_row(32'hC300_0000, 1, 32'hC300_0000);  // -128 is exact
    add_row(32'hC300_0001, 1, 32'hC300_0000);  // just below -128
    add_row(32'h7F7F_FFFF, 1, 32'h42FF_FE00);  // largest finite
    add_row(32'h3F80_0000, 1, 32'h3F80_0000);  // 1.0 exact
    add_row(32'h3FFF_FFFF, 0, 32'h0);           // truncation inside range
    add_row(32'hC2FF_FFFF, 0, 32'h0);
    add_row(32'h3B80_0000, 0, 32'h0);           // exactly one grid step
    add_row(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
    foreach (directed[i]) begin
      send_sample(directed[i].sample, directed[i].typed, directed[i].want);
    end

    // Register settings, extremes first; out-of-range codes saturate.
    settings = '{'{6'd1, 6'd0}, '{6'd32, 6'd32}, '{6'd0, 6'd63}, '{6'd63, 6'd0},
                 '{6'd1, 6'd32}, '{6'd32, 6'd0}, '{6'd16, 6'd9}, '{6'd2, 6'd3},
                 '{6'd12, 6'd12}, '{6'd8, 6'd8}, '{6'd21, 6'd42}, '{6'd5, 6'd19}};
    foreach (settings[s]) begin
      write_register(REG_INT_BITS, settings[s][0]);
      write_register(REG_FRACTION_BITS, settings[s][1]);
      // The second phase runs with no idling; one phase holds the receiver off.
      calm = (s == 1);
      if (s == 3) begin
        fork
          begin
            hold_sink = 1'b1;
            repeat (60) @(posedge clk);
            hold_sink = 1'b0;
          end
        join_none
      end
      send_sample(32'h7F80_0000, 0, 32'h0);
      send_sample(32'hFF80_0000, 0, 32'h0);
      for (int i = 0; i < RandomItems / $size(settings); i++) begin
        send_sample(random_sample(), 0, 32'h0);
      end
      calm = 1'b0;
    end
    din.valid <= 1'b0;

    while (pending_values.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    $display("Covered %0d samples over %0d register settings, %0d results checked.",
             sent_count, $size(settings) + 1, recv_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
